[hdl/assert_macros.svh]
// ----------------------------------------------------------------------------
// assert_macros.svh
// Shared concurrent assertion macros, sampled on a clock and held off in reset
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// antecedent in a cycle implies consequent in that same cycle
`define ASSERT_IMPLY(label, clk, rst_n, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("assertion failed: label");

// antecedent in a cycle implies consequent in the cycle after
`define ASSERT_NEXT(label, clk, rst_n, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("assertion failed: label");

`endif

[hdl/mei_pkg.sv]
// ----------------------------------------------------------------------------
// mei_pkg
// Types and constants shared by the escape-time iterator modules
// ----------------------------------------------------------------------------
package mei_pkg;

  localparam int FIELD_W  = 32;
  localparam int CODE_W   = 12;
  localparam int LIMIT_W  = 10;

  localparam logic [LIMIT_W-1:0]       LIMIT_RESET = 10'd255;
  localparam logic signed [CODE_W-1:0] CODE_INSIDE = 12'sd128;
  localparam logic signed [CODE_W-1:0] CODE_SKIP_BELOW = -12'sd256;

  typedef struct packed {
    logic signed [FIELD_W-1:0] c_real;
    logic signed [FIELD_W-1:0] c_imag;
    logic signed [CODE_W-1:0]  prior_code;
  } in_item_t;

  typedef struct packed {
    logic signed [CODE_W-1:0] result_code;
    logic                     skipped;
  } out_item_t;

  // controller to datapath
  typedef struct packed {
    logic load;        // capture a new point
    logic mul;         // register the three products of z
    logic step;        // z <= z*z + c, count up
    logic set_escape;  // result is minus the count
    logic set_inside;  // result is the bounded code
    logic push;        // move result into the output register
  } mei_cmd_t;

  // datapath to controller
  typedef struct packed {
    logic skip;        // incoming prior code is passed through
    logic escaped;     // |z|^2 above four after at least one iteration
    logic at_limit;    // iteration count reached the limit
    logic out_free;    // output register can take a result this cycle
  } mei_sts_t;

endpackage

[hdl/mei_ctrl.sv]
// ----------------------------------------------------------------------------
// mei_ctrl
// Sequencer: accept a point, alternate multiply and update cycles, hand off
// ----------------------------------------------------------------------------
module mei_ctrl (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              in_valid,
  output logic              in_stall,
  input  mei_pkg::mei_sts_t sts,
  output mei_pkg::mei_cmd_t cmd
);
  import mei_pkg::*;

  typedef enum logic [3:0] {
    ST_IDLE = 4'b0001,
    ST_MUL  = 4'b0010,
    ST_EVAL = 4'b0100,
    ST_DONE = 4'b1000
  } state_t;

  state_t state_r, state_nxt;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

  assign in_stall = (state_r != ST_IDLE);

  always_comb begin
    state_nxt = state_r;
    cmd       = '0;
    case (state_r)
      ST_IDLE: begin
        if (in_valid) begin
          cmd.load  = 1'b1;
          state_nxt = sts.skip ? ST_DONE : ST_MUL;
        end
      end
      ST_MUL: begin
        cmd.mul   = 1'b1;
        state_nxt = ST_EVAL;
      end
      ST_EVAL: begin
        if (sts.escaped) begin
          cmd.set_escape = 1'b1;
          state_nxt      = ST_DONE;
        end else if (sts.at_limit) begin
          cmd.set_inside = 1'b1;
          state_nxt      = ST_DONE;
        end else begin
          cmd.step  = 1'b1;
          state_nxt = ST_MUL;
        end
      end
      ST_DONE: begin
        if (sts.out_free) begin
          cmd.push  = 1'b1;
          state_nxt = ST_IDLE;
        end
      end
      default: begin
        state_nxt = ST_IDLE;
      end
    endcase
  end

endmodule

[hdl/mei_dp.sv]
// ----------------------------------------------------------------------------
// mei_dp
// Datapath: z registers, product registers, update with saturation, escape
// compare, iteration counter and the output register
// ----------------------------------------------------------------------------
module mei_dp #(
  parameter int COORD_WIDTH = 32,
  parameter int FRAC_BITS   = 28,
  parameter int MAX_ITER    = 1023
) (
  input  logic                            clk,
  input  logic                            rst_n,
  input  mei_pkg::in_item_t               in_data,
  input  logic [mei_pkg::LIMIT_W-1:0]     max_iters,
  input  mei_pkg::mei_cmd_t               cmd,
  output mei_pkg::mei_sts_t               sts,
  output logic                            out_valid,
  input  logic                            out_stall,
  output mei_pkg::out_item_t              out_data
);
  import mei_pkg::*;

  localparam int W   = COORD_WIDTH;
  localparam int PW  = 2 * COORD_WIDTH;
  localparam int K_W = $clog2(MAX_ITER + 1);
  localparam logic [PW:0] THRESH = {{PW{1'b0}}, 1'b1} << (2 * FRAC_BITS + 2);

  logic signed [W-1:0]  cr_r, ci_r, zr_r, zi_r;
  logic signed [PW-1:0] rr_r, ii_r, ri_r;
  logic [K_W-1:0]       k_r, limit;
  logic signed [CODE_W-1:0] res_r;
  logic                 skip_r;
  logic                 out_valid_r;
  out_item_t            out_data_r;

  logic [2*FIELD_W-1:0] cr_ext, ci_ext;
  logic signed [PW:0]   re_full, im_full, re_sh, im_sh;
  logic [PW+1:0]        re_sum, im_sum;
  logic [W-1:0]         zr_new, zi_new;
  logic [PW:0]          mag;

  function automatic logic [W-1:0] sat_coord(input logic [PW+1:0] v);
    logic fits;
    fits = (&v[PW+1:W-1]) || !(|v[PW+1:W-1]);
    if (fits) begin
      return v[W-1:0];
    end else if (v[PW+1]) begin
      return {1'b1, {(W-1){1'b0}}};
    end else begin
      return {1'b0, {(W-1){1'b1}}};
    end
  endfunction

  // low coordinate bits taken as a signed value, wider coordinates sign-extend
  assign cr_ext = {{FIELD_W{in_data.c_real[FIELD_W-1]}}, in_data.c_real};
  assign ci_ext = {{FIELD_W{in_data.c_imag[FIELD_W-1]}}, in_data.c_imag};

  assign limit = (max_iters > LIMIT_W'(MAX_ITER)) ? K_W'(MAX_ITER) : max_iters[K_W-1:0];

  // z*z + c at double width, then shift down and saturate
  assign re_full = {rr_r[PW-1], rr_r} - {ii_r[PW-1], ii_r};
  assign im_full = {ri_r, 1'b0};
  assign re_sh   = re_full >>> FRAC_BITS;
  assign im_sh   = im_full >>> FRAC_BITS;
  assign re_sum  = {re_sh[PW], re_sh} + {{(PW+2-W){cr_r[W-1]}}, cr_r};
  assign im_sum  = {im_sh[PW], im_sh} + {{(PW+2-W){ci_r[W-1]}}, ci_r};
  assign zr_new  = sat_coord(re_sum);
  assign zi_new  = sat_coord(im_sum);

  // squares are of the current z, so this tests the iterate counted by k_r
  assign mag = {1'b0, rr_r} + {1'b0, ii_r};

  assign sts.skip     = (in_data.prior_code == CODE_INSIDE) ||
                        (in_data.prior_code < CODE_SKIP_BELOW);
  assign sts.escaped  = (k_r != '0) && (mag > THRESH);
  assign sts.at_limit = (k_r == limit);
  assign sts.out_free = !out_valid_r || !out_stall;

  always_ff @(posedge clk) begin
    if (cmd.load) begin
      cr_r   <= cr_ext[W-1:0];
      ci_r   <= ci_ext[W-1:0];
      zr_r   <= cr_ext[W-1:0];
      zi_r   <= ci_ext[W-1:0];
      k_r    <= '0;
      res_r  <= in_data.prior_code;
      skip_r <= 1'b1;
    end
    if (cmd.mul) begin
      rr_r <= zr_r * zr_r;
      ii_r <= zi_r * zi_r;
      ri_r <= zr_r * zi_r;
    end
    if (cmd.step) begin
      zr_r <= zr_new;
      zi_r <= zi_new;
      k_r  <= k_r + K_W'(1);
    end
    if (cmd.set_escape) begin
      res_r  <= CODE_W'(0) - CODE_W'(k_r);
      skip_r <= 1'b0;
    end
    if (cmd.set_inside) begin
      res_r  <= CODE_INSIDE;
      skip_r <= 1'b0;
    end
    if (cmd.push) begin
      out_data_r.result_code <= res_r;
      out_data_r.skipped     <= skip_r;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (cmd.push) begin
      out_valid_r <= 1'b1;
    end else if (!out_stall) begin
      out_valid_r <= 1'b0;
    end
  end

  assign out_valid = out_valid_r;
  assign out_data  = out_data_r;

endmodule

[hdl/mandelbrot_escape_iterator_top.sv]
// ----------------------------------------------------------------------------
// mandelbrot_escape_iterator_top
// Escape-time classifier for one complex point per transfer
// ----------------------------------------------------------------------------
// One point is worked on at a time. A point whose prior code is passed through
// goes from its transfer straight to the done state and is pushed into the
// output register once that register is free. Otherwise each iteration has a
// multiply state that registers the three products of z and an evaluate state
// that forms the next z and tests the squares. A point that escapes or reaches
// the limit goes to the done state and then waits for a free output register.
// The next point is taken as soon as the result sits in the output register,
// even while that result is still stalled.
module mandelbrot_escape_iterator_top #(
  parameter int COORD_WIDTH = 32,
  parameter int FRAC_BITS   = 28,
  parameter int MAX_ITER    = 1023
) (
  input  logic                         clk,
  input  logic                         rst_n,
  input  logic                         in_valid,
  output logic                         in_stall,
  input  mei_pkg::in_item_t            in_data,
  output logic                         out_valid,
  input  logic                         out_stall,
  output mei_pkg::out_item_t           out_data,
  input  logic                         cfg_we,
  input  logic [mei_pkg::LIMIT_W-1:0]  cfg_wdata
);
  import mei_pkg::*;

  logic [LIMIT_W-1:0] max_iters_r;
  mei_cmd_t           cmd;
  mei_sts_t           sts;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      max_iters_r <= LIMIT_RESET;
    end else if (cfg_we) begin
      max_iters_r <= cfg_wdata;
    end
  end

  mei_ctrl u_ctrl (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_valid),
    .in_stall (in_stall),
    .sts      (sts),
    .cmd      (cmd)
  );

  mei_dp #(
    .COORD_WIDTH (COORD_WIDTH),
    .FRAC_BITS   (FRAC_BITS),
    .MAX_ITER    (MAX_ITER)
  ) u_dp (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_data    (in_data),
    .max_iters  (max_iters_r),
    .cmd        (cmd),
    .sts        (sts),
    .out_valid  (out_valid),
    .out_stall  (out_stall),
    .out_data   (out_data)
  );

`include "assert_macros.svh"

  // a result never overwrites one still waiting in the output register
  `ASSERT_IMPLY(a_push_free, clk, rst_n, cmd.push, sts.out_free)
  // z only advances when it neither escaped nor hit the limit
  `ASSERT_IMPLY(a_step_legal, clk, rst_n, cmd.step, !sts.escaped && !sts.at_limit)
  // output valid rises only from a push in the cycle before
  `ASSERT_IMPLY(a_valid_src, clk, rst_n, $rose(out_valid), $past(cmd.push))
  // after a new point is taken the block stalls its input
  `ASSERT_NEXT(a_busy_after_load, clk, rst_n, cmd.load, in_stall)

endmodule
